FILE: design/pqfm_pkg.sv
// Shared types and constants for the packet queue with extract-min.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pqfm_pkg;

  localparam int DEPTH    = 16;
  localparam int HANDLE_W = 32;
  localparam int PTS_W    = 64;
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int ENTRY_W  = HANDLE_W + PTS_W;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_EXT = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    enq;
    logic    clr;
    logic    scan_init;
    logic    scan_run;
    logic    shift_init;
    logic    shift_run;
    logic    remove;
    logic    respond;
    status_e rsp_status;
    logic    rsp_data;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e op;
    logic empty;
    logic full;
    logic scan_done;
    logic shift_done;
  } dp_sts_t;

endpackage

FILE: design/packet_queue_fifo_min_pts.sv
// Packet queue with oldest-first and smallest-timestamp removal, one beat at a time.
// Enqueue, clear, and full/empty reports: done_o is registered from the decode state after the start beat.
// Dequeue scans only the oldest entry; extract-min scans every entry. Both then compact the younger
// entries through the single read port of the entry memory, one entry a cycle for scan and compaction.
// Reset clears the controller and the fill count; entry contents stay undefined.
// Results strobe done_o for one cycle and are not held; the receiver cannot stall.
`timescale 1ns / 1ps

module packet_queue_fifo_min_pts import pqfm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd_i,
  input  logic [HANDLE_W-1:0]      packet_handle_i,
  input  logic signed [PTS_W-1:0]  packet_pts_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [HANDLE_W-1:0]      out_handle_o,
  output logic signed [PTS_W-1:0]  out_pts_o,
  output logic [CW-1:0]            count_after_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  pqfm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd)
  );

  pqfm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .in_cmd_i      (cmd_i),
    .in_handle_i   (packet_handle_i),
    .in_pts_i      (packet_pts_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .out_handle_o  (out_handle_o),
    .out_pts_o     (out_pts_o),
    .count_after_o (count_after_o)
  );

  // a result beat always lands with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while sequencer busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start beat not taken");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> ((out_handle_o == '0) && (out_pts_o == '0)))
    else $error("error result carries entry data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (count_after_o <= CW'(DEPTH)))
    else $error("count beyond depth");

endmodule

FILE: design/pqfm_ctrl.sv
// Sequencer for the packet queue: decode, scan, compaction and response.
// Depends on pqfm_pkg; drives the datapath through dp_cmd_t only.
`timescale 1ns / 1ps

module pqfm_ctrl import pqfm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.op) inside
          CMD_ENQ: begin
            cmd_o.respond = 1'b1;
            if (sts_i.full) begin
              cmd_o.rsp_status = ST_FULL;
            end else begin
              cmd_o.enq        = 1'b1;
              cmd_o.rsp_status = ST_OK;
            end
            state_d = S_IDLE;
          end
          CMD_CLR: begin
            cmd_o.clr        = 1'b1;
            cmd_o.respond    = 1'b1;
            cmd_o.rsp_status = ST_OK;
            state_d          = S_IDLE;
          end
          CMD_DEQ, CMD_EXT: begin
            if (sts_i.empty) begin
              cmd_o.respond    = 1'b1;
              cmd_o.rsp_status = ST_EMPTY;
              state_d          = S_IDLE;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          // gap closed: drop the entry and report it
          cmd_o.remove     = 1'b1;
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_status = ST_OK;
          cmd_o.rsp_data   = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.shift_run = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: design/pqfm_dp.sv
// Datapath for the packet queue: entry memory, fill count, min scan, result registers.
// Depends on pqfm_pkg; sequenced by pqfm_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module pqfm_dp import pqfm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  input  logic [1:0]                 in_cmd_i,
  input  logic [HANDLE_W-1:0]        in_handle_i,
  input  logic signed [PTS_W-1:0]    in_pts_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [HANDLE_W-1:0]        out_handle_o,
  output logic signed [PTS_W-1:0]    out_pts_o,
  output logic [CW-1:0]              count_after_o
);

  // entry memory: oldest at address 0
  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // captured command beat
  cmd_e                     op_q;
  logic [HANDLE_W-1:0]      in_handle_q;
  logic signed [PTS_W-1:0]  in_pts_q;

  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            rd_ptr_q, rd_ptr_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [AW-1:0]            rd_addr_q, rd_addr_d;

  logic                     have_best_q, have_best_d;
  logic [AW-1:0]            best_idx_q, best_idx_d;
  logic [HANDLE_W-1:0]      best_handle_q, best_handle_d;
  logic signed [PTS_W-1:0]  best_pts_q, best_pts_d;

  logic                     done_q;
  status_e                  status_q;
  logic [HANDLE_W-1:0]      out_handle_q;
  logic signed [PTS_W-1:0]  out_pts_q;
  logic [CW-1:0]            count_out_q;

  logic [CW-1:0]            scan_limit;
  logic signed [PTS_W-1:0]  rd_pts;
  logic [HANDLE_W-1:0]      rd_handle;

  assign rd_pts    = $signed(rd_data_q[PTS_W-1:0]);
  assign rd_handle = rd_data_q[ENTRY_W-1:PTS_W];

  // dequeue is a scan over the oldest entry only
  assign scan_limit = (op_q == CMD_DEQ) ? CW'(1) : count_q;

  assign sts_o.op         = op_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CW'(DEPTH));
  assign sts_o.scan_done  = (rd_ptr_q >= scan_limit) && !rd_vld_q;
  assign sts_o.shift_done = (rd_ptr_q >= count_q) && !rd_vld_q;

  always_comb begin
    count_d       = count_q;
    rd_ptr_d      = rd_ptr_q;
    rd_vld_d      = 1'b0;
    rd_addr_d     = rd_addr_q;
    have_best_d   = have_best_q;
    best_idx_d    = best_idx_q;
    best_handle_d = best_handle_q;
    best_pts_d    = best_pts_q;
    mem_we        = 1'b0;
    mem_waddr     = count_q[AW-1:0];
    mem_wdata     = {in_handle_q, in_pts_q};
    mem_re        = 1'b0;
    mem_raddr     = rd_ptr_q[AW-1:0];

    if (cmd_i.enq) begin
      mem_we  = 1'b1;
      count_d = count_q + CW'(1);
    end

    if (cmd_i.clr) begin
      count_d = '0;
    end

    if (cmd_i.scan_init) begin
      rd_ptr_d    = '0;
      have_best_d = 1'b0;
    end

    if (cmd_i.scan_run) begin
      if (rd_ptr_q < scan_limit) begin
        mem_re    = 1'b1;
        rd_vld_d  = 1'b1;
        rd_addr_d = rd_ptr_q[AW-1:0];
        rd_ptr_d  = rd_ptr_q + CW'(1);
      end
      // <= while walking oldest to newest: a tie goes to the newest
      if (rd_vld_q && (!have_best_q || (rd_pts <= best_pts_q))) begin
        have_best_d   = 1'b1;
        best_idx_d    = rd_addr_q;
        best_handle_d = rd_handle;
        best_pts_d    = rd_pts;
      end
    end

    if (cmd_i.shift_init) begin
      rd_ptr_d = {1'b0, best_idx_q} + CW'(1);
    end

    if (cmd_i.shift_run) begin
      if (rd_ptr_q < count_q) begin
        mem_re    = 1'b1;
        rd_vld_d  = 1'b1;
        rd_addr_d = rd_ptr_q[AW-1:0];
        rd_ptr_d  = rd_ptr_q + CW'(1);
      end
      // move the younger entry up by one slot
      if (rd_vld_q) begin
        mem_we    = 1'b1;
        mem_waddr = rd_addr_q - AW'(1);
        mem_wdata = rd_data_q;
      end
    end

    if (cmd_i.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= cmd_e'(in_cmd_i);
      in_handle_q <= in_handle_i;
      in_pts_q    <= in_pts_i;
    end
    rd_addr_q     <= rd_addr_d;
    best_idx_q    <= best_idx_d;
    best_handle_q <= best_handle_d;
    best_pts_q    <= best_pts_d;
    if (cmd_i.respond) begin
      status_q     <= cmd_i.rsp_status;
      out_handle_q <= cmd_i.rsp_data ? best_handle_q : '0;
      out_pts_q    <= cmd_i.rsp_data ? best_pts_q : '0;
      count_out_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_vld_q    <= rd_vld_d;
      have_best_q <= have_best_d;
      done_q      <= cmd_i.respond;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_handle_o  = out_handle_q;
  assign out_pts_o     = out_pts_q;
  assign count_after_o = count_out_q;

endmodule

FILE: test/tb_top.sv
// Self-checking bench for packet_queue_fifo_min_pts: directed corner cases, then random traffic.
// Depends on pqfm_pkg and the DUT; keeps its own copy of the queue to predict each result.
`timescale 1ns / 1ps

module tb_top;
  import pqfm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    status_e                status;
    logic [HANDLE_W-1:0]    handle;
    logic signed [PTS_W-1:0] pts;
    logic [CW-1:0]          count;
  } queue_rsp_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               cmd_i = CMD_CLR;
  logic [HANDLE_W-1:0]      packet_handle_i = '0;
  logic signed [PTS_W-1:0]  packet_pts_i = '0;
  logic                     done_o;
  logic [1:0]               status_o;
  logic [HANDLE_W-1:0]      out_handle_o;
  logic signed [PTS_W-1:0]  out_pts_o;
  logic [CW-1:0]            count_after_o;

  // mirror of the stored entries, oldest at index 0
  logic [HANDLE_W-1:0]      q_handle [DEPTH];
  logic signed [PTS_W-1:0]  q_pts [DEPTH];
  int                       q_count = 0;

  queue_rsp_t               expected_rsp_q [$];
  queue_rsp_t               exp_rsp;
  int                       sender_idle_pct = 0;
  int                       mismatches = 0;
  int                       cmds_sent = 0;
  int                       rsps_checked = 0;
  int                       full_seen = 0;
  int                       empty_seen = 0;
  int                       stall_cycles = 0;

  packet_queue_fifo_min_pts dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .packet_handle_i(packet_handle_i),
    .packet_pts_i   (packet_pts_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_handle_o   (out_handle_o),
    .out_pts_o      (out_pts_o),
    .count_after_o  (count_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the mirror and queue the result it must produce.
  function automatic void predict_queue_op(input cmd_e op, input logic [HANDLE_W-1:0] h,
                                           input logic signed [PTS_W-1:0] p);
    queue_rsp_t r;
    int pick;
    r.status = ST_OK;
    r.handle = '0;
    r.pts = '0;
    case (op)
      CMD_ENQ: begin
        if (q_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          q_handle[q_count] = h;
          q_pts[q_count] = p;
          q_count++;
        end
      end
      CMD_DEQ, CMD_EXT: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pick = 0;
          // less-or-equal so that a tie lands on the newest entry
          if (op == CMD_EXT)
            for (int i = 1; i < q_count; i++)
              if (q_pts[i] <= q_pts[pick]) pick = i;
          r.handle = q_handle[pick];
          r.pts = q_pts[pick];
          for (int i = pick; i < q_count - 1; i++) begin
            q_handle[i] = q_handle[i + 1];
            q_pts[i] = q_pts[i + 1];
          end
          q_count--;
        end
      end
      default: q_count = 0;
    endcase
    r.count = CW'(q_count);
    expected_rsp_q.push_back(r);
  endfunction

  // Hold start until the beat is taken, then maybe park the sender for a while.
  task automatic send_cmd(input cmd_e op, input logic [HANDLE_W-1:0] h,
                          input logic signed [PTS_W-1:0] p);
    start <= 1'b1;
    cmd_i <= op;
    packet_handle_i <= h;
    packet_pts_i <= p;
    do @(posedge clk_i); while (busy);
    predict_queue_op(op, h, p);
    cmds_sent++;
    // idle each following cycle with the current odds
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    logic [HANDLE_W-1:0] hs [DEPTH] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0003,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h0000_0007,
      32'h7FFF_FFFF, 32'h0000_0009, 32'hDEAD_0010, 32'h0000_0011,
      32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0014, 32'h0000_0015};
    logic signed [PTS_W-1:0] ps [DEPTH] = '{
      64'h0000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h5555_5555_5555_5555,
      64'hFFFF_FFFF_FFFF_FFFB, 64'hAAAA_AAAA_AAAA_AAAA, 64'h7FFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0002,
      64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_0000_0000,
      64'h8000_0000_0000_0001};
    // removals on an empty queue
    send_cmd(CMD_DEQ, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_EXT, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
    for (int i = 0; i < DEPTH; i++) send_cmd(CMD_ENQ, hs[i], ps[i]);
    send_cmd(CMD_ENQ, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
    // two entries share the most negative stamp: newest first, then the older one
    send_cmd(CMD_EXT, '0, '0);
    send_cmd(CMD_EXT, '0, '0);
    send_cmd(CMD_DEQ, '0, '0);
    send_cmd(CMD_EXT, '0, '0);
    send_cmd(CMD_CLR, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_CLR, '0, '0);
  endtask

  function automatic logic signed [PTS_W-1:0] rand_pts();
    int v;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom_range(0, 7);
        rand_pts = PTS_W'(v - 4);   // narrow range so ties are frequent
      end
      1: rand_pts = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      default: rand_pts = {$urandom, $urandom};
    endcase
  endfunction

  // Random walk between filling and draining bursts so the queue swings
  // between empty and full, with the odd clear and full/empty hit.
  task automatic test_random(input int n_items);
    bit filling;
    int r;
    filling = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (q_count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (q_count == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3)
        send_cmd(CMD_CLR, $urandom, rand_pts());
      else if (r < (filling ? 72 : 28))
        send_cmd(CMD_ENQ, $urandom, rand_pts());
      else if ($urandom_range(0, 99) < 45)
        send_cmd(CMD_DEQ, $urandom, rand_pts());
      else
        send_cmd(CMD_EXT, $urandom, rand_pts());
    end
  endtask

  task automatic check_field(input string name, input logic [PTS_W-1:0] want,
                             input logic [PTS_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, status %0d handle %0h pts %0h",
                 $time, status_o, out_handle_o, out_pts_o);
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        check_field("status", PTS_W'(exp_rsp.status), PTS_W'(status_o));
        check_field("out_handle", PTS_W'(exp_rsp.handle), PTS_W'(out_handle_o));
        check_field("out_pts", exp_rsp.pts, out_pts_o);
        check_field("count_after", PTS_W'(exp_rsp.count), PTS_W'(count_after_o));
        if (exp_rsp.status == ST_FULL) full_seen++;
        if (exp_rsp.status == ST_EMPTY) empty_seen++;
        rsps_checked++;
      end
    end
  end

  // Abort when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 29;
    test_directed();
    test_random(342);
    sender_idle_pct = 87;
    test_random(342);
    sender_idle_pct = 0;
    test_random(342);
    if (start) start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d commands, checked %0d results", cmds_sent, rsps_checked);
    $display("full reports %0d, empty reports %0d, leftover %0d",
             full_seen, empty_seen, expected_rsp_q.size());
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pqfm_pkg.sv
design/pqfm_ctrl.sv
design/pqfm_dp.sv
design/packet_queue_fifo_min_pts.sv
test/tb_top.sv
